[hw/rtl/utf8_rune_decoder_assert.svh]
// Assertion macros for the UTF-8 rune decoder.
// Expects a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef UTF8_RUNE_DECODER_ASSERT_SVH
`define UTF8_RUNE_DECODER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define U8D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds starting in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 rune decoder.
// No dependencies; used by the lane, merge and top-level modules.
`default_nettype none

package u8d_pkg;

  localparam int NUM_LANES = 4;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [2:0] CONSUMED_NUL  = 3'd0;
  localparam logic [2:0] CONSUMED_SKIP = 3'd1;

  // Sequence length that a lane assumes for the leader byte.
  typedef enum logic [1:0] {
    RLEN_1 = 2'd0,
    RLEN_2 = 2'd1,
    RLEN_3 = 2'd2,
    RLEN_4 = 2'd3
  } rune_len_t;

  // What one lane found in the window.
  typedef struct packed {
    logic        match;
    logic [2:0]  consumed;
    logic [20:0] code_point;
    logic        err;
  } lane_res_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/u8d_lane.sv]
// One decode lane: checks the window against a single sequence length.
// Depends on u8d_pkg for the lane result type and the length codes.
`default_nettype none

module u8d_lane
  import u8d_pkg::*;
(
  input  rune_len_t   len_i,
  input  logic        narrow_i,
  input  logic [7:0]  b0_i,
  input  logic [7:0]  b1_i,
  input  logic [7:0]  b2_i,
  input  logic [7:0]  b3_i,
  output lane_res_t   res_o
);

  logic        c1;
  logic        c2;
  logic        c3;
  logic        lead_ok;
  logic        conts_ok;
  logic        range_err;
  logic [20:0] cp;

  assign c1 = is_cont(b1_i);
  assign c2 = is_cont(b2_i);
  assign c3 = is_cont(b3_i);

  always_comb begin
    lead_ok   = 1'b0;
    conts_ok  = 1'b0;
    range_err = 1'b1;
    cp        = '0;
    case (len_i)
      RLEN_1: begin
        lead_ok   = (b0_i[7] == 1'b0);
        conts_ok  = 1'b1;
        cp        = {13'd0, b0_i};
        range_err = 1'b0;
      end
      RLEN_2: begin
        lead_ok   = ((b0_i & 8'hE0) == 8'hC0);
        conts_ok  = c1;
        cp        = {10'd0, b0_i[4:0], b1_i[5:0]};
        range_err = (cp < 21'h00080);
      end
      RLEN_3: begin
        lead_ok   = ((b0_i & 8'hF0) == 8'hE0);
        conts_ok  = c1 & c2;
        cp        = {5'd0, b0_i[3:0], b1_i[5:0], b2_i[5:0]};
        range_err = (cp < 21'h00800) || ((cp >= 21'h0D800) && (cp <= 21'h0DFFF));
      end
      RLEN_4: begin
        lead_ok   = ((b0_i & 8'hF8) == 8'hF0);
        conts_ok  = c1 & c2 & c3;
        cp        = {b0_i[2:0], b1_i[5:0], b2_i[5:0], b3_i[5:0]};
        // A four-byte rune cannot be represented in narrow mode.
        range_err = narrow_i || (cp < 21'h10000) || (cp > 21'h10FFFF);
      end
      default: begin
        lead_ok   = 1'b0;
        conts_ok  = 1'b0;
        range_err = 1'b1;
        cp        = '0;
      end
    endcase
  end

  always_comb begin
    res_o.match      = lead_ok & conts_ok;
    res_o.consumed   = 3'({1'b0, len_i}) + 3'd1;
    res_o.code_point = range_err ? 21'd0 : cp;
    res_o.err        = range_err;
  end

endmodule

`default_nettype wire

[hw/rtl/u8d_merge.sv]
// Merge stage: picks the lane whose length matched, or reports a one-byte skip; a terminator overrides both.
// Depends on u8d_pkg for the lane result type and the consumed codes.
`default_nettype none

module u8d_merge
  import u8d_pkg::*;
(
  input  lane_res_t   lanes_i [NUM_LANES],
  input  logic        nul_i,
  output lane_res_t   res_o
);

  always_comb begin
    // No lane matched: a missing continuation or a stray leader skips one byte.
    res_o.match      = 1'b1;
    res_o.consumed   = CONSUMED_SKIP;
    res_o.code_point = '0;
    res_o.err        = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lanes_i[i].match) begin
        res_o = lanes_i[i];
      end
    end
    if (nul_i) begin
      res_o.match      = 1'b1;
      res_o.consumed   = CONSUMED_NUL;
      res_o.code_point = '0;
      res_o.err        = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/utf8_rune_decoder.sv]
// Top level of the UTF-8 rune decoder: four length lanes, a merge stage and the ports.
// Depends on u8d_pkg, u8d_lane, u8d_merge and utf8_rune_decoder_assert.svh.
//
//   Channel   Handshake            Payload
//   input     start / busy         in_byte_first .. in_byte_fourth
//   result    out_strobe           out_consumed, out_code_point, out_bad_seq
//   config    cfg_we               cfg_wdata (narrow_mode)
//
// One request is accepted every clock cycle; busy never rises.
// Each accepted request is registered in stages: the first register
// stage holds the four lane results, the second holds the merged result.
// Synchronous active-low reset clears the stage valids and narrow_mode.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

`include "utf8_rune_decoder_assert.svh"

module utf8_rune_decoder
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_byte_first,
  input  logic [7:0]  in_byte_second,
  input  logic [7:0]  in_byte_third,
  input  logic [7:0]  in_byte_fourth,

  output logic        out_strobe,
  output logic [2:0]  out_consumed,
  output logic [20:0] out_code_point,
  output logic        out_bad_seq,

  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic      narrow_r;
  logic      narrow_nxt;
  logic      accept;

  lane_res_t lane_res     [NUM_LANES];
  lane_res_t lane_res_r   [NUM_LANES];
  logic      nul_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;

  lane_res_t merged;
  logic      out_strobe_r;
  logic      out_strobe_nxt;
  logic [2:0]  out_consumed_r;
  logic [20:0] out_code_point_r;
  logic        out_bad_seq_r;

  // The pipeline has no stalls, so a request is always taken.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration register; the user must write it only while no request is in flight (not enforced here).
  assign narrow_nxt = cfg_we ? cfg_wdata : narrow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r <= 1'b0;
    end else begin
      narrow_r <= narrow_nxt;
    end
  end

  // Each lane assumes one sequence length and checks leader, continuations
  // and range for it. Leader patterns are disjoint, so at most one matches.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    u8d_lane u_lane (
      .len_i    (rune_len_t'(g)),
      .narrow_i (narrow_r),
      .b0_i     (in_byte_first),
      .b1_i     (in_byte_second),
      .b2_i     (in_byte_third),
      .b3_i     (in_byte_fourth),
      .res_o    (lane_res[g])
    );
  end

  // Stage one: capture the lane results and the terminator flag.
  assign s1_valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lane_res_r <= lane_res;
      nul_r      <= (in_byte_first == 8'd0);
    end
  end

  // Stage two: merge the lanes and register the result for the output ports.
  u8d_merge u_merge (
    .lanes_i (lane_res_r),
    .nul_i   (nul_r),
    .res_o   (merged)
  );

  assign out_strobe_nxt = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_consumed_r   <= merged.consumed;
      out_code_point_r <= merged.code_point;
      out_bad_seq_r    <= merged.err;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_consumed   = out_consumed_r;
  assign out_code_point = out_code_point_r;
  assign out_bad_seq    = out_bad_seq_r;

  // Every accepted request yields a result once it has passed both register stages.
  `U8D_ASSERT_NEXT(a_latency, accept, ##1 out_strobe, "result missing two cycles after request")

  // Leader patterns are disjoint, so no two lanes may claim the same window.
  `U8D_ASSERT_SAME(a_lane_excl, s1_valid_r,
    $onehot0({lane_res_r[0].match, lane_res_r[1].match,
              lane_res_r[2].match, lane_res_r[3].match}),
    "more than one decode lane matched")

  // A flagged result never carries a code point.
  `U8D_ASSERT_SAME(a_err_zero, out_strobe && out_bad_seq, out_code_point == 21'd0,
    "code point nonzero on decode error")

  // A terminator result is clean and empty.
  `U8D_ASSERT_SAME(a_nul_clean, out_strobe && (out_consumed == CONSUMED_NUL),
    !out_bad_seq && (out_code_point == 21'd0), "terminator result not clean")

endmodule

`default_nettype wire
